// ===== design/hota_pkg.sv =====
// Package for the head orientation to axes block: word types, register
// indexes, control word layout and the sequencer program.
// No dependencies.
`timescale 1ns / 1ps

package hota_pkg;

    localparam int QUAT_FRAC_DEFAULT = 14;
    localparam int QUAT_W            = 16;
    localparam int AXIS_W            = 16;
    localparam int MAG_W             = 15;
    localparam int CFG_INDEX_W       = 1;
    localparam int CFG_DATA_W        = 32;
    localparam int TIME_W            = 32;
    localparam int CAL_W             = 2;
    localparam int STATUS_W          = 4;
    localparam int STEP_W            = 5;

    localparam logic [MAG_W-1:0]  MAG_RESET     = 15'd16384;
    localparam logic [TIME_W-1:0] HOLDOFF_RESET = 32'd100000;
    localparam logic [CAL_W-1:0]  CAL_FULL      = 2'd3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_AXIS_MAGNITUDE   = 1'b0,
        REG_RECENTER_HOLDOFF = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [QUAT_W-1:0] quat_w;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
        logic                     button_pressed;
        logic [TIME_W-1:0]        time_us;
        logic [CAL_W-1:0]         cal_system;
        logic [CAL_W-1:0]         cal_gyro;
        logic [CAL_W-1:0]         cal_accel;
        logic [CAL_W-1:0]         cal_mag;
    } in_word_t;

    typedef struct packed {
        logic signed [AXIS_W-1:0] axis_x;
        logic signed [AXIS_W-1:0] axis_y;
        logic signed [AXIS_W-1:0] axis_rz;
        logic [STATUS_W-1:0]      status_buttons;
        logic                     recentered;
    } out_word_t;

    typedef enum logic [0:0] {
        S_IDLE,
        S_RUN
    } state_t;

    // Multiplier operand sources
    typedef enum logic [3:0] {
        OPD_QW, OPD_QX, OPD_QY, OPD_QZ,
        OPD_RW, OPD_RX, OPD_RY, OPD_RZ,
        OPD_PW, OPD_PX, OPD_PY, OPD_PZ,
        OPD_M2, OPD_D
    } opd_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [3:0] {
        STO_NONE,
        STO_PW, STO_PX, STO_PY, STO_PZ,
        STO_D,
        STO_AX0, STO_AX1, STO_AX2
    } store_t;

    typedef enum logic [0:0] {
        NX_STEP,
        NX_WAIT_OUT
    } seq_t;

    typedef struct packed {
        logic    mul_en;
        opd_t    opa;
        opd_t    opb;
        acc_op_t acc;
        store_t  sto;
        seq_t    seq;
    } ucode_t;

    // Product issued in a step is accumulated in the next step; a store
    // takes the accumulator (or, for axes, the product) as it stood before
    // the step.
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t uc;
        case (step)
            5'd0:  uc = '{1'b1, OPD_QW, OPD_RW, ACC_HOLD, STO_NONE, NX_STEP};
            5'd1:  uc = '{1'b1, OPD_QX, OPD_RX, ACC_LOAD, STO_NONE, NX_STEP};
            5'd2:  uc = '{1'b1, OPD_QY, OPD_RY, ACC_ADD,  STO_NONE, NX_STEP};
            5'd3:  uc = '{1'b1, OPD_QZ, OPD_RZ, ACC_ADD,  STO_NONE, NX_STEP};
            5'd4:  uc = '{1'b1, OPD_QW, OPD_RX, ACC_ADD,  STO_NONE, NX_STEP};
            5'd5:  uc = '{1'b1, OPD_QX, OPD_RW, ACC_LOAD, STO_PW,   NX_STEP};
            5'd6:  uc = '{1'b1, OPD_QY, OPD_RZ, ACC_SUB,  STO_NONE, NX_STEP};
            5'd7:  uc = '{1'b1, OPD_QZ, OPD_RY, ACC_SUB,  STO_NONE, NX_STEP};
            5'd8:  uc = '{1'b1, OPD_QW, OPD_RY, ACC_ADD,  STO_NONE, NX_STEP};
            5'd9:  uc = '{1'b1, OPD_QX, OPD_RZ, ACC_LOAD, STO_PX,   NX_STEP};
            5'd10: uc = '{1'b1, OPD_QY, OPD_RW, ACC_ADD,  STO_NONE, NX_STEP};
            5'd11: uc = '{1'b1, OPD_QZ, OPD_RX, ACC_SUB,  STO_NONE, NX_STEP};
            5'd12: uc = '{1'b1, OPD_QW, OPD_RZ, ACC_SUB,  STO_NONE, NX_STEP};
            5'd13: uc = '{1'b1, OPD_QX, OPD_RY, ACC_LOAD, STO_PY,   NX_STEP};
            5'd14: uc = '{1'b1, OPD_QY, OPD_RX, ACC_SUB,  STO_NONE, NX_STEP};
            5'd15: uc = '{1'b1, OPD_QZ, OPD_RW, ACC_ADD,  STO_NONE, NX_STEP};
            5'd16: uc = '{1'b1, OPD_PX, OPD_PY, ACC_SUB,  STO_NONE, NX_STEP};
            5'd17: uc = '{1'b0, OPD_PX, OPD_PY, ACC_LOAD, STO_PZ,   NX_STEP};
            5'd18: uc = '{1'b1, OPD_PW, OPD_PZ, ACC_HOLD, STO_NONE, NX_STEP};
            5'd19: uc = '{1'b1, OPD_PX, OPD_PZ, ACC_SUB,  STO_NONE, NX_STEP};
            5'd20: uc = '{1'b1, OPD_PW, OPD_PY, ACC_LOAD, STO_D,    NX_STEP};
            5'd21: uc = '{1'b1, OPD_M2, OPD_D,  ACC_ADD,  STO_NONE, NX_STEP};
            5'd22: uc = '{1'b0, OPD_M2, OPD_D,  ACC_HOLD, STO_D,    NX_STEP};
            5'd23: uc = '{1'b1, OPD_M2, OPD_D,  ACC_HOLD, STO_AX0,  NX_STEP};
            5'd24: uc = '{1'b1, OPD_PY, OPD_PZ, ACC_HOLD, STO_AX1,  NX_STEP};
            5'd25: uc = '{1'b1, OPD_PW, OPD_PX, ACC_LOAD, STO_NONE, NX_STEP};
            5'd26: uc = '{1'b0, OPD_PW, OPD_PX, ACC_SUB,  STO_NONE, NX_STEP};
            5'd27: uc = '{1'b0, OPD_PW, OPD_PX, ACC_HOLD, STO_D,    NX_STEP};
            5'd28: uc = '{1'b1, OPD_M2, OPD_D,  ACC_HOLD, STO_NONE, NX_STEP};
            5'd29: uc = '{1'b0, OPD_M2, OPD_D,  ACC_HOLD, STO_AX2,  NX_STEP};
            5'd30: uc = '{1'b0, OPD_M2, OPD_D,  ACC_HOLD, STO_NONE, NX_WAIT_OUT};
            default: uc = '{1'b0, OPD_M2, OPD_D, ACC_HOLD, STO_NONE, NX_WAIT_OUT};
        endcase
        return uc;
    endfunction

endpackage

// ===== design/head_orientation_to_axes.sv =====
// Head orientation to axes: microcoded multiply-accumulate sequencer that
// turns an orientation quaternion into three joystick axes.
// Depends on hota_pkg (word types, register indexes, sequencer program).
`timescale 1ns / 1ps

// Usage
//   in_valid/in_ready/in_data carry one sample word; out_valid/out_ready/
//   out_data carry one result word. A word moves when valid and ready are
//   both high at a clock edge.
//   cfg_we/cfg_index/cfg_data write axis_magnitude (index 0) or
//   recenter_holdoff_us (index 1); write only while idle.
//   A sample with an all-zero quaternion is taken and dropped at once.
//   Any other sample runs a 31-step program on one shared signed
//   multiplier and one accumulator: 16 products for conj(q)*ref, 6 for the
//   axis combinations, 3 for the scaling by 2M. out_valid rises and
//   in_ready returns in the same cycle, so a new sample is not taken
//   before the last one's result is done. The multiplier is used in 25
//   of the steps.
//   The result sits in an output register; a new sample is taken while it
//   waits. If the receiver still stalls when the next result is done, the
//   program holds on its last step until the output register frees.
//   Reset (rst_n low, asynchronous) restores the identity reference, the
//   register defaults, the button enable and an empty output register.

module head_orientation_to_axes
    import hota_pkg::*;
#(
    parameter int QUAT_FRAC_BITS = QUAT_FRAC_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_word_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_word_t              out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int F     = QUAT_FRAC_BITS;
    localparam int PW    = 34 - F;                 // |p| <= 2^(32-F)
    localparam int DCW   = 2 * F + 2;              // clamped combination
    localparam int OPW   = (PW > DCW) ? PW : DCW;  // multiplier operand
    localparam int PRW   = 2 * OPW;
    localparam int AW    = PRW + 2;
    localparam int IDENT = ((1 << F) > 32767) ? 32767 : (1 << F);

    localparam logic signed [QUAT_W-1:0] IDENT_W = QUAT_W'(IDENT);
    localparam logic signed [AW-1:0]     P_BIAS  = (AW'(1) <<< F) - AW'(1);
    localparam logic signed [AW-1:0]     D_LIM   = AW'(1) <<< (2 * F);
    localparam logic signed [PRW-1:0]    AX_BIAS = (PRW'(1) <<< (2 * F)) - PRW'(1);

    // Sequencer state
    state_t             state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    ucode_t             uc;
    logic               running;
    logic               accept;
    logic               nonzero;
    logic               load_out;
    logic               out_free;

    // Configuration
    logic [MAG_W-1:0]   mag_reg;
    logic [TIME_W-1:0]  holdoff_reg;

    // Recenter state
    logic signed [QUAT_W-1:0] ref_reg [0:3];
    logic [TIME_W-1:0]        last_time_reg;
    logic                     enable_reg;
    logic                     guard_reg;
    logic [TIME_W-1:0]        elapsed;
    logic                     recen;
    logic                     enable_next;

    // Datapath
    logic signed [QUAT_W-1:0] q_reg [0:3];
    logic signed [PW-1:0]     p_reg [0:3];
    logic signed [DCW-1:0]    d_reg;
    logic signed [PRW-1:0]    prod_reg, prod_next;
    logic signed [AW-1:0]     acc_reg, acc_next;
    logic signed [AXIS_W-1:0] ax_reg [0:2];
    logic [STATUS_W-1:0]      status_reg;
    logic                     recent_reg;
    logic signed [OPW-1:0]    opa_val, opb_val;
    logic signed [OPW-1:0]    m2_val;
    logic signed [AW-1:0]     acc_biased, acc_shift;
    logic signed [PW-1:0]     p_val;
    logic signed [DCW-1:0]    d_val;
    logic signed [PRW-1:0]    prod_biased, ax_shift, m_s;
    logic signed [AXIS_W-1:0] ax_val;

    // Output register
    logic                     out_valid_reg;
    out_word_t                out_data_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign nonzero   = (in_data.quat_w != '0) || (in_data.quat_x != '0) ||
                       (in_data.quat_y != '0) || (in_data.quat_z != '0);
    assign running   = (state_reg == S_RUN);
    assign uc        = ucode_rom(step_reg);
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign elapsed     = in_data.time_us - last_time_reg;
    assign recen       = in_data.button_pressed && (elapsed > holdoff_reg);
    assign enable_next = (recen && !guard_reg) ? !enable_reg : enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        load_out   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && nonzero)
                begin
                    state_next = S_RUN;
                    step_next  = '0;
                end
            end
            S_RUN:
            begin
                case (uc.seq)
                    NX_WAIT_OUT:
                    begin
                        // hold on the last step until the output register frees
                        if (out_free)
                        begin
                            load_out   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        step_next = step_reg + STEP_W'(1);
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg     <= MAG_RESET;
            holdoff_reg <= HOLDOFF_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_AXIS_MAGNITUDE:   mag_reg     <= cfg_data[MAG_W-1:0];
                REG_RECENTER_HOLDOFF: holdoff_reg <= cfg_data[TIME_W-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg[0]    <= IDENT_W;
            ref_reg[1]    <= '0;
            ref_reg[2]    <= '0;
            ref_reg[3]    <= '0;
            last_time_reg <= '0;
            enable_reg    <= 1'b1;
            guard_reg     <= 1'b0;
        end
        else if (accept && nonzero)
        begin
            if (recen)
            begin
                ref_reg[0]    <= in_data.quat_w;
                ref_reg[1]    <= in_data.quat_x;
                ref_reg[2]    <= in_data.quat_y;
                ref_reg[3]    <= in_data.quat_z;
                last_time_reg <= in_data.time_us;
                enable_reg    <= enable_next;
                guard_reg     <= 1'b1;
            end
            else
            begin
                guard_reg <= 1'b0;
            end
        end
    end

    // Latch the sample and its flags
    always_ff @(posedge clk)
    begin
        if (accept && nonzero)
        begin
            q_reg[0]   <= in_data.quat_w;
            q_reg[1]   <= in_data.quat_x;
            q_reg[2]   <= in_data.quat_y;
            q_reg[3]   <= in_data.quat_z;
            recent_reg <= recen;
            status_reg <= enable_next ? {in_data.cal_mag    != CAL_FULL,
                                         in_data.cal_accel  != CAL_FULL,
                                         in_data.cal_gyro   != CAL_FULL,
                                         in_data.cal_system != CAL_FULL}
                                      : '0;
        end
    end

    assign m2_val = OPW'({1'b0, mag_reg, 1'b0});

    always_comb
    begin
        case (uc.opa)
            OPD_QW:  opa_val = OPW'(q_reg[0]);
            OPD_QX:  opa_val = OPW'(q_reg[1]);
            OPD_QY:  opa_val = OPW'(q_reg[2]);
            OPD_QZ:  opa_val = OPW'(q_reg[3]);
            OPD_PW:  opa_val = OPW'(p_reg[0]);
            OPD_PX:  opa_val = OPW'(p_reg[1]);
            OPD_PY:  opa_val = OPW'(p_reg[2]);
            OPD_PZ:  opa_val = OPW'(p_reg[3]);
            OPD_M2:  opa_val = m2_val;
            default: opa_val = '0;
        endcase
    end

    always_comb
    begin
        case (uc.opb)
            OPD_RW:  opb_val = OPW'(ref_reg[0]);
            OPD_RX:  opb_val = OPW'(ref_reg[1]);
            OPD_RY:  opb_val = OPW'(ref_reg[2]);
            OPD_RZ:  opb_val = OPW'(ref_reg[3]);
            OPD_PW:  opb_val = OPW'(p_reg[0]);
            OPD_PX:  opb_val = OPW'(p_reg[1]);
            OPD_PY:  opb_val = OPW'(p_reg[2]);
            OPD_PZ:  opb_val = OPW'(p_reg[3]);
            OPD_D:   opb_val = OPW'(d_reg);
            default: opb_val = '0;
        endcase
    end

    assign prod_next = opa_val * opb_val;

    always_comb
    begin
        case (uc.acc)
            ACC_LOAD: acc_next = AW'(prod_reg);
            ACC_ADD:  acc_next = acc_reg + AW'(prod_reg);
            ACC_SUB:  acc_next = acc_reg - AW'(prod_reg);
            default:  acc_next = acc_reg;
        endcase
    end

    // p component: divide the sum by 2^F, truncating toward zero
    assign acc_biased = acc_reg[AW-1] ? (acc_reg + P_BIAS) : acc_reg;
    assign acc_shift  = acc_biased >>> F;
    assign p_val      = acc_shift[PW-1:0];

    // combination clamped to +-2^(2F)
    always_comb
    begin
        if (acc_reg > D_LIM)
            d_val = D_LIM[DCW-1:0];
        else if (acc_reg < -D_LIM)
            d_val = -(D_LIM[DCW-1:0]);
        else
            d_val = acc_reg[DCW-1:0];
    end

    // axis: 2M*D / 2^(2F) toward zero, saturated to +-M
    assign prod_biased = prod_reg[PRW-1] ? (prod_reg + AX_BIAS) : prod_reg;
    assign ax_shift    = prod_biased >>> (2 * F);
    assign m_s         = PRW'({1'b0, mag_reg});

    always_comb
    begin
        if (ax_shift > m_s)
            ax_val = m_s[AXIS_W-1:0];
        else if (ax_shift < -m_s)
            ax_val = -(m_s[AXIS_W-1:0]);
        else
            ax_val = ax_shift[AXIS_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (running)
        begin
            if (uc.mul_en)
                prod_reg <= prod_next;
            acc_reg <= acc_next;
            case (uc.sto)
                STO_PW:  p_reg[0]  <= p_val;
                STO_PX:  p_reg[1]  <= p_val;
                STO_PY:  p_reg[2]  <= p_val;
                STO_PZ:  p_reg[3]  <= p_val;
                STO_D:   d_reg     <= d_val;
                STO_AX0: ax_reg[0] <= ax_val;
                STO_AX1: ax_reg[1] <= ax_val;
                STO_AX2: ax_reg[2] <= ax_val;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg.axis_x         <= ax_reg[0];
            out_data_reg.axis_y         <= ax_reg[1];
            out_data_reg.axis_rz        <= ax_reg[2];
            out_data_reg.status_buttons <= status_reg;
            out_data_reg.recentered     <= recent_reg;
        end
    end

endmodule

// ===== design/hota_checker.sv =====
// Port-level checker for head_orientation_to_axes, bound to the top level.
// Depends on hota_pkg (word types).
`timescale 1ns / 1ps

module hota_checker
    import hota_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_word_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_data
);

    logic in_zero;

    assign in_zero = (in_data.quat_w == '0) && (in_data.quat_x == '0) &&
                     (in_data.quat_y == '0) && (in_data.quat_z == '0);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // a real sample keeps the sequencer busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_zero |=> !in_ready)
        else $error("input taken again right after a sample");

    // a dropped sample never makes a result
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_zero && !out_valid |=> !out_valid)
        else $error("zero quaternion produced a result");

    // saturation keeps axes inside +-M, so the most negative code never shows
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.axis_x != 16'h8000) && (out_data.axis_y != 16'h8000) &&
                      (out_data.axis_rz != 16'h8000))
        else $error("axis outside saturation range");

endmodule

bind head_orientation_to_axes hota_checker u_hota_checker (.*);
